/* rtl/stab_address_line_lookup_defines.svh */
// Assertion macros for the stab address-to-line lookup checker.
// Included by the checker file only.
`ifndef STAB_ADDRESS_LINE_LOOKUP_DEFINES_SVH
`define STAB_ADDRESS_LINE_LOOKUP_DEFINES_SVH

// Implication checked every clock, off while reset is asserted.
`define SALL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Invariant that must hold every clock out of reset.
`define SALL_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`endif

/* rtl/sall_pkg.sv */
// Shared types and constants of the stab address-to-line lookup.
// No dependencies.
package sall_pkg;

    // Symbol entry type codes
    localparam logic [7:0] TY_SO    = 8'h64;
    localparam logic [7:0] TY_FUN   = 8'h24;
    localparam logic [7:0] TY_SLINE = 8'h44;
    localparam logic [7:0] TY_SOL   = 8'h84;
    localparam logic [7:0] TY_PSYM  = 8'ha0;

    // Commands carried on tuser
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
    localparam logic [1:0] REG_STR_SIZE    = 2'd1;
    localparam logic [1:0] REG_STR_TERM    = 2'd2;

    typedef struct packed {
        logic [7:0]  ty;
        logic [15:0] desc;
        logic [31:0] value;
        logic [31:0] strx;
    } t_entry;

endpackage

/* rtl/sall_tbl.sv */
// Symbol table storage: one write port, one read port, registered read data.
// Depends on sall_pkg (t_entry).
module sall_tbl #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  sall_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output sall_pkg::t_entry o_rdata
);
    import sall_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/stab_address_line_lookup.sv */
// Stab address-to-line lookup: symbol table in one synchronous RAM, walked by a sequencer.
// Write transaction: taken while idle, no result. Lookup: one RAM read per probe;
// three type-filtered binary searches, a backward file-name scan and an argument scan.
// One item in flight at a time.
// Reset (synchronous, i_rst_n low) clears control and config registers; datapath and table contents undefined.
module stab_address_line_lookup #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // stream in
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // [9:0] entry_index, [17:10] entry_type, [33:18] entry_desc,
    // [65:34] entry_value, [97:66] entry_strx, [129:98] lookup_address
    input  logic [135:0]  i_s_tdata,
    // [0] command
    input  logic [0:0]    i_s_tuser,
    // stream out
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // [15:0] line, [47:16] fn_addr, [79:48] fn_name_offset, [80] fn_name_known,
    // [112:81] file_offset, [113] file_known, [123:114] arg_count
    output logic [127:0]  o_m_tdata,
    // [0] status
    output logic [0:0]    o_m_tuser,
    // APB config
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import sall_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW = IW + 2;   // signed index, holds -1 .. TABLE_DEPTH

    typedef logic signed [SW-1:0] t_idx;

    // one-hot sequencer states
    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_NLOOP   = 16'h0002,  // binary search: next probe
        S_NSCAN   = 16'h0004,  // binary search: walk down to a matching type
        S_NFIN    = 16'h0008,
        S_NKCHK   = 16'h0010,  // final walk from right to left
        S_NKDAT   = 16'h0020,
        S_NDONE   = 16'h0040,  // dispatch by search phase
        S_FUNDAT  = 16'h0080,
        S_LINEDAT = 16'h0100,
        S_SCHK    = 16'h0200,  // backward scan for file name
        S_SDAT    = 16'h0400,
        S_ACHK    = 16'h0800,  // argument count scan
        S_ADAT    = 16'h1000,
        S_OUT     = 16'h2000,
        S_ARGS    = 16'h4000,
        S_SPARE   = 16'h8000   // unused code, falls back to idle
    } t_state;

    typedef enum logic [1:0] {
        PH_FILE = 2'd0,
        PH_FUN  = 2'd1,
        PH_LINE = 2'd2
    } t_phase;

    // config registers
    logic [10:0] r_cfg_count;
    logic [31:0] r_cfg_size;
    logic        r_cfg_term;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    t_idx   r_l, n_l, r_r, n_r, r_mid, n_mid, r_m, n_m, r_k, n_k;
    t_idx   r_left, n_left, r_right, n_right;
    t_idx   r_lfile, n_lfile, r_rfile, n_rfile, r_lfun, n_lfun, r_rfun, n_rfun;
    logic   r_found, n_found;
    logic [7:0]  r_ty, n_ty;
    logic [31:0] r_key, n_key, r_addr, n_addr;

    // result being built
    logic        r_status, n_status;
    logic [15:0] r_line, n_line;
    logic [31:0] r_fnaddr, n_fnaddr, r_fnoff, n_fnoff, r_fileoff, n_fileoff;
    logic        r_fnknown, n_fnknown, r_fileknown, n_fileknown;
    logic [9:0]  r_nargs, n_nargs;

    // output holding register
    logic         r_ovalid;
    logic [127:0] r_odata;
    logic         r_ostat;
    logic         load_out;

    // table port
    logic        tbl_we;
    t_entry      tbl_wdata, tbl_rdata;
    t_idx        rd_idx;

    logic        s_acc;
    logic [9:0]  in_idx;
    logic [31:0] cnt32, n_used;
    t_idx        t_mid, t_m1;

    assign pready = 1'b1;
    assign s_acc  = i_s_tvalid && o_s_tready;
    assign in_idx = i_s_tdata[9:0];
    assign o_s_tready = (r_state == S_IDLE);

    assign tbl_wdata = '{ty: i_s_tdata[17:10], desc: i_s_tdata[33:18],
                         value: i_s_tdata[65:34], strx: i_s_tdata[97:66]};
    assign tbl_we = s_acc && (i_s_tuser[0] == CMD_WRITE)
                    && (32'(in_idx) < 32'(TABLE_DEPTH));

    // entries in use, clamped to the table depth
    assign cnt32  = 32'(r_cfg_count);
    assign n_used = (cnt32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt32;

    assign t_mid = r_l + ((r_r - r_l) >>> 1);
    assign t_m1  = r_m - t_idx'(1);

    sall_tbl #(.DEPTH(TABLE_DEPTH), .AW(IW)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (IW'(in_idx)),
        .i_wdata (tbl_wdata),
        .i_raddr (rd_idx[IW-1:0]),
        .o_rdata (tbl_rdata)
    );

    // APB
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= '0;
            r_cfg_size  <= '0;
            r_cfg_term  <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_ENTRY_COUNT: r_cfg_count <= pwdata[10:0];
                REG_STR_SIZE:    r_cfg_size  <= pwdata;
                REG_STR_TERM:    r_cfg_term  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ENTRY_COUNT: prdata = {21'd0, r_cfg_count};
            REG_STR_SIZE:    prdata = r_cfg_size;
            REG_STR_TERM:    prdata = {31'd0, r_cfg_term};
            default:         prdata = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;   n_phase = r_phase;
        n_l = r_l;  n_r = r_r;  n_mid = r_mid;  n_m = r_m;  n_k = r_k;
        n_left = r_left;  n_right = r_right;  n_found = r_found;
        n_lfile = r_lfile;  n_rfile = r_rfile;  n_lfun = r_lfun;  n_rfun = r_rfun;
        n_ty = r_ty;  n_key = r_key;  n_addr = r_addr;
        n_status = r_status;  n_line = r_line;  n_fnaddr = r_fnaddr;
        n_fnoff = r_fnoff;  n_fnknown = r_fnknown;
        n_fileoff = r_fileoff;  n_fileknown = r_fileknown;  n_nargs = r_nargs;
        rd_idx = '0;
        load_out = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc && (i_s_tuser[0] == CMD_LOOKUP)) begin
                    n_addr = i_s_tdata[129:98];
                    n_status = 1'b1;  n_line = '0;  n_fnaddr = i_s_tdata[129:98];
                    n_fnoff = '0;  n_fnknown = 1'b0;
                    n_fileoff = '0;  n_fileknown = 1'b0;  n_nargs = '0;
                    if (r_cfg_size == '0 || !r_cfg_term) begin
                        n_state = S_OUT;
                    end else begin
                        n_phase = PH_FILE;
                        n_l = '0;  n_left = '0;
                        n_r = t_idx'(n_used) - t_idx'(1);  n_right = n_r;
                        n_found = 1'b0;  n_ty = TY_SO;  n_key = i_s_tdata[129:98];
                        n_state = S_NLOOP;
                    end
                end
            end
            S_NLOOP: begin
                if (r_l <= r_r) begin
                    n_mid = t_mid;  n_m = t_mid;  rd_idx = t_mid;
                    n_state = S_NSCAN;
                end else begin
                    n_state = S_NFIN;
                end
            end
            S_NSCAN: begin
                if (tbl_rdata.ty == r_ty) begin
                    n_found = 1'b1;
                    if (tbl_rdata.value < r_key) begin
                        n_left = r_m;  n_l = r_mid + t_idx'(1);
                    end else if (tbl_rdata.value > r_key) begin
                        n_right = t_m1;  n_r = t_m1;
                    end else begin
                        n_left = r_m;  n_l = r_m;  n_key = r_key + 32'd1;
                    end
                    n_state = S_NLOOP;
                end else if (t_m1 < r_l) begin
                    n_l = r_mid + t_idx'(1);
                    n_state = S_NLOOP;
                end else begin
                    n_m = t_m1;  rd_idx = t_m1;
                end
            end
            S_NFIN: begin
                if (!r_found) begin
                    n_right = r_left - t_idx'(1);
                    n_state = S_NDONE;
                end else begin
                    n_k = r_right;
                    n_state = S_NKCHK;
                end
            end
            S_NKCHK: begin
                if (r_k > r_left) begin
                    rd_idx = r_k;
                    n_state = S_NKDAT;
                end else begin
                    n_left = r_k;
                    n_state = S_NDONE;
                end
            end
            S_NKDAT: begin
                if (tbl_rdata.ty != r_ty) begin
                    n_k = r_k - t_idx'(1);
                    n_state = S_NKCHK;
                end else begin
                    n_left = r_k;
                    n_state = S_NDONE;
                end
            end
            S_NDONE: begin
                n_found = 1'b0;
                unique case (r_phase)
                    PH_FILE: begin
                        n_lfile = r_left;  n_rfile = r_right;
                        if (r_left == '0) begin
                            n_state = S_OUT;
                        end else begin
                            n_phase = PH_FUN;  n_ty = TY_FUN;  n_key = r_addr;
                            n_l = r_left;  n_r = r_right;
                            n_state = S_NLOOP;
                        end
                    end
                    PH_FUN: begin
                        n_lfun = r_left;  n_rfun = r_right;
                        if (r_left <= r_right) begin
                            rd_idx = r_left;
                            n_state = S_FUNDAT;
                        end else begin
                            // no function: search lines over the whole file
                            n_phase = PH_LINE;  n_ty = TY_SLINE;  n_key = r_addr;
                            n_left = r_lfile;  n_right = r_rfile;
                            n_l = r_lfile;  n_r = r_rfile;
                            n_state = S_NLOOP;
                        end
                    end
                    PH_LINE: begin
                        if (r_left <= r_right) begin
                            rd_idx = r_left;  n_k = r_left;
                            n_state = S_LINEDAT;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_FUNDAT: begin
                if (tbl_rdata.strx < r_cfg_size) begin
                    n_fnoff = tbl_rdata.strx;  n_fnknown = 1'b1;
                end
                n_fnaddr = tbl_rdata.value;
                n_phase = PH_LINE;  n_ty = TY_SLINE;
                n_key = r_addr - tbl_rdata.value;   // address relative to function
                n_left = r_lfun;  n_right = r_rfun;  n_l = r_lfun;  n_r = r_rfun;
                n_state = S_NLOOP;
            end
            S_LINEDAT: begin
                n_line = tbl_rdata.desc;
                n_status = 1'b0;
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (r_k >= r_lfile) begin
                    rd_idx = r_k;
                    n_state = S_SDAT;
                end else begin
                    n_state = S_ARGS;
                end
            end
            S_SDAT: begin
                if (tbl_rdata.ty == TY_SOL
                    || (tbl_rdata.ty == TY_SO && tbl_rdata.value != '0)) begin
                    if (tbl_rdata.strx < r_cfg_size) begin
                        n_fileoff = tbl_rdata.strx;  n_fileknown = 1'b1;
                    end
                    n_state = S_ARGS;
                end else begin
                    n_k = r_k - t_idx'(1);
                    n_state = S_SCHK;
                end
            end
            S_ARGS: begin
                n_k = r_lfun + t_idx'(1);
                n_state = (r_lfun < r_rfun) ? S_ACHK : S_OUT;
            end
            S_ACHK: begin
                if (r_k < r_rfun) begin
                    rd_idx = r_k;
                    n_state = S_ADAT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_ADAT: begin
                if (tbl_rdata.ty == TY_PSYM) begin
                    n_nargs = r_nargs + 10'd1;
                    n_k = r_k + t_idx'(1);
                    n_state = S_ACHK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_FILE;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_found <= n_found;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_l <= n_l;  r_r <= n_r;  r_mid <= n_mid;  r_m <= n_m;  r_k <= n_k;
        r_left <= n_left;  r_right <= n_right;
        r_lfile <= n_lfile;  r_rfile <= n_rfile;  r_lfun <= n_lfun;  r_rfun <= n_rfun;
        r_ty <= n_ty;  r_key <= n_key;  r_addr <= n_addr;
        r_status <= n_status;  r_line <= n_line;  r_fnaddr <= n_fnaddr;
        r_fnoff <= n_fnoff;  r_fnknown <= n_fnknown;
        r_fileoff <= n_fileoff;  r_fileknown <= n_fileknown;  r_nargs <= n_nargs;
        if (load_out) begin
            r_ostat <= r_status;
            r_odata <= {4'd0, r_nargs, r_fileknown, r_fileoff, r_fnknown, r_fnoff,
                        r_fnaddr, r_line};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ostat;
endmodule

/* rtl/sall_chk.sv */
// Port-level checker for stab_address_line_lookup, bound to the top level.
// Depends on stab_address_line_lookup_defines.svh.
`include "stab_address_line_lookup_defines.svh"

module sall_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [0:0]   i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [127:0] o_m_tdata,
    input logic [0:0]   o_m_tuser,
    input logic         pready
);
    `SALL_ALWAYS(a_pready_high, pready, "pready must stay high")
    `SALL_ASSERT(a_out_hold, (o_m_tvalid && !i_m_tready) |=> o_m_tvalid, "result dropped while stalled")
    `SALL_ASSERT(a_write_silent, (i_s_tvalid && o_s_tready && !i_s_tuser[0] && !o_m_tvalid) |=> !o_m_tvalid, "write transaction produced a result")
    `SALL_ASSERT(a_lookup_busy, (i_s_tvalid && o_s_tready && i_s_tuser[0]) |=> !o_s_tready, "lookup did not block input")
    `SALL_ASSERT(a_fail_fields, (o_m_tvalid && o_m_tuser[0]) |-> (!o_m_tdata[113] && o_m_tdata[123:114] == 10'd0), "failed lookup reports file or args")
endmodule

bind stab_address_line_lookup sall_chk u_sall_chk (.*);
